[rtl/core/glyph_atlas_shelf_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator assertion macros
// Concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef GLYPH_ATLAS_SHELF_ALLOCATOR_MACROS_SVH
`define GLYPH_ATLAS_SHELF_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every edge outside reset
`define GASA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("glyph atlas assertion failed");
// Checked on every edge, reset included
`define GASA_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("glyph atlas assertion failed");
`else
`define GASA_ASSERT(label, prop)
`define GASA_ASSERT_ALWAYS(label, prop)
`endif

`endif

[rtl/core/gasa_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator package
// Shared constants, item types, status codes and the class height function.
// ----------------------------------------------------------------------------
package gasa_pkg;

	localparam int DEF_MAX_PAGES    = 64;
	localparam int DEF_PAGE_SIDE    = 256;
	localparam int DEF_SIZE_CLASSES = 4;

	// Smallest class height; each further class doubles it
	localparam int BASE_CLASS_H = 16;
	localparam int CLASS_H_W    = 12;

	typedef enum logic [1:0] {
		ST_PLACED   = 2'd0,
		ST_NEW_PAGE = 2'd1,
		ST_TOO_TALL = 2'd2,
		ST_NO_PAGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] glyph_width;
		logic [7:0] glyph_height;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] page_number;
		logic [8:0] place_x;
		logic [7:0] place_y;
	} rsp_t;

	// Controller to datapath command
	typedef struct packed {
		logic place;
	} cmd_t;

	function automatic logic [CLASS_H_W-1:0] class_height(input logic [2:0] cls);
		class_height = CLASS_H_W'(BASE_CLASS_H) << cls;
	endfunction

endpackage

[rtl/core/gasa_ctrl.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator controller
// Tracks the result register and decides when a request item is taken.
// ----------------------------------------------------------------------------
module gasa_ctrl
	import gasa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	output cmd_t cmd
);

	typedef enum logic {
		S_EMPTY,
		S_FULL
	} state_t;

	state_t state_q;

	// Take a new item unless a finished result is held back
	assign req_stall = (state_q == S_FULL) && rsp_stall;
	assign cmd.place = req_valid && !req_stall;
	assign rsp_valid = (state_q == S_FULL);

	// Fill on placement, drain when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			case (state_q)
				S_EMPTY: begin
					if (cmd.place) state_q <= S_FULL;
				end
				S_FULL: begin
					if (!rsp_stall && !cmd.place) state_q <= S_EMPTY;
				end
				default: state_q <= S_EMPTY;
			endcase
		end
	end

endmodule

[rtl/core/gasa_datapath.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator datapath
// Per-class page and shelf cursors, page counter and the result register.
// ----------------------------------------------------------------------------
`include "glyph_atlas_shelf_allocator_macros.svh"

module gasa_datapath
	import gasa_pkg::*;
#(
	parameter int MAX_PAGES    = DEF_MAX_PAGES,
	parameter int PAGE_SIDE    = DEF_PAGE_SIDE,
	parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  req_t req,
	output rsp_t rsp
);

	localparam int CLS_W  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
	localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PU_W   = $clog2(MAX_PAGES + 1);
	localparam int MAX_H  = BASE_CLASS_H << (SIZE_CLASSES - 1);
	localparam int X_SPAN = (PAGE_SIDE > 256) ? PAGE_SIDE : 256;
	localparam int X_W    = $clog2(X_SPAN + 2);
	localparam int Y_W    = $clog2(PAGE_SIDE);
	localparam int AW     = $clog2(PAGE_SIDE + 2 * MAX_H + X_SPAN + 4) + 1;

	logic [PG_W-1:0] page_q   [SIZE_CLASSES];
	logic            has_q    [SIZE_CLASSES];
	logic [X_W-1:0]  cur_x_q  [SIZE_CLASSES];
	logic [Y_W-1:0]  cur_y_q  [SIZE_CLASSES];
	logic [PU_W-1:0] pages_used_q;
	rsp_t            rsp_q;

	logic [CLS_W-1:0] sel;
	logic             sel_found;
	logic [AW-1:0]    size_a;
	logic [AW-1:0]    row_x;
	logic [AW-1:0]    row_y;
	logic [AW-1:0]    next_x;
	logic             need_new;
	logic             pages_out;
	logic             place_ok;
	logic [15:0]      page_ext;
	rsp_t             rsp_d;

	// Pick the first class taller than the glyph
	always_comb begin
		sel       = '0;
		sel_found = 1'b0;
		for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
			if ({{(CLASS_H_W-8){1'b0}}, req.glyph_height} < class_height(3'(i))) begin
				sel       = CLS_W'(i);
				sel_found = 1'b1;
			end
		end
	end

	// Fit the glyph on the current shelf, the next shelf, or a fresh page
	always_comb begin
		size_a = AW'(class_height(3'(sel)));
		row_x  = AW'(cur_x_q[sel]);
		row_y  = AW'(cur_y_q[sel]);
		next_x = AW'(req.glyph_width);
		need_new = 1'b1;
		if (has_q[sel]) begin
			next_x = row_x + AW'(req.glyph_width);
			if (next_x > AW'(PAGE_SIDE)) begin
				row_x  = '0;
				next_x = AW'(req.glyph_width);
				row_y  = row_y + size_a + AW'(1);
			end
			need_new = (row_y + size_a + AW'(1)) > AW'(PAGE_SIDE);
		end
		if (need_new) begin
			row_x  = '0;
			row_y  = '0;
			next_x = AW'(req.glyph_width);
		end
		pages_out = need_new && (pages_used_q >= PU_W'(MAX_PAGES));
		page_ext  = need_new ? 16'(pages_used_q) : 16'(page_q[sel]);

		rsp_d.status      = need_new ? ST_NEW_PAGE : ST_PLACED;
		rsp_d.page_number = page_ext[5:0];
		rsp_d.place_x     = row_x[8:0];
		rsp_d.place_y     = row_y[7:0];
		if (!sel_found) begin
			rsp_d = '{status: ST_TOO_TALL, page_number: '0, place_x: '0, place_y: '0};
		end else if (pages_out) begin
			rsp_d = '{status: ST_NO_PAGE, page_number: '0, place_x: '0, place_y: '0};
		end
	end

	// Commit only a taken item that fits a class and finds a page
	assign place_ok = cmd.place && sel_found && !pages_out;

	// Update chosen class on successful placement, page counter on a new page
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIZE_CLASSES; i++) begin
				page_q[i]  <= '0;
				has_q[i]   <= 1'b0;
				cur_x_q[i] <= '0;
				cur_y_q[i] <= '0;
			end
			pages_used_q <= '0;
		end else if (place_ok) begin
			if (need_new) begin
				page_q[sel]  <= PG_W'(pages_used_q);
				has_q[sel]   <= 1'b1;
				pages_used_q <= pages_used_q + 1'b1;
			end
			cur_x_q[sel] <= X_W'(next_x + AW'(1));
			cur_y_q[sel] <= Y_W'(row_y);
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk) begin
		if (cmd.place) rsp_q <= rsp_d;
	end

	assign rsp = rsp_q;

	`GASA_ASSERT_ALWAYS(a_pages_bound, pages_used_q <= PU_W'(MAX_PAGES))
	`GASA_ASSERT(a_new_page_count, place_ok && need_new |=> pages_used_q == $past(pages_used_q) + 1'b1)
	`GASA_ASSERT(a_fail_keeps_count, cmd.place && !place_ok |=> $stable(pages_used_q))
	`GASA_ASSERT(a_placed_on_page, cmd.place && rsp_d.status == ST_PLACED |-> has_q[sel])

	for (genvar g = 0; g < SIZE_CLASSES; g++) begin : g_chk
		`GASA_ASSERT(a_page_issued, has_q[g] |-> PU_W'(page_q[g]) < pages_used_q)
	end

endmodule

[rtl/core/glyph_atlas_shelf_allocator.sv]
// ----------------------------------------------------------------------------
// Glyph atlas shelf allocator
// Places glyphs on per-size-class shelves of square atlas pages.
// ----------------------------------------------------------------------------
// Timing: the result is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle unless a held result stalls requests; the
//   class cursor read-modify-write is combinational up to the result register.
// Reset: arst_n clears every class (no page, cursors at zero) and the page
//   counter at once; the block accepts items as soon as reset is released.
module glyph_atlas_shelf_allocator
	import gasa_pkg::*;
#(
	parameter int MAX_PAGES    = DEF_MAX_PAGES,
	parameter int PAGE_SIDE    = DEF_PAGE_SIDE,
	parameter int SIZE_CLASSES = DEF_SIZE_CLASSES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;

	// Handshake and result register occupancy
	gasa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// Shelf state and placement arithmetic
	gasa_datapath #(
		.MAX_PAGES    (MAX_PAGES),
		.PAGE_SIDE    (PAGE_SIDE),
		.SIZE_CLASSES (SIZE_CLASSES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
